// File: rtl/led_matrix_char_framebuffer_assert.svh
// assertion macros for the led matrix character frame buffer
// no dependencies; included by the top level
`ifndef LED_MATRIX_CHAR_FRAMEBUFFER_ASSERT_SVH
`define LED_MATRIX_CHAR_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LMCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lmcf check failed");

// next-cycle implication, disabled during reset
`define LMCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lmcf check failed");

`endif

// File: rtl/lmcf_pkg.sv
// shared types and constants for the led matrix character frame buffer
// no dependencies
`timescale 1ns / 1ps

package lmcf_pkg;

    // operation codes
    localparam logic [2:0] FUNC_LOAD_GLYPH  = 3'd0;
    localparam logic [2:0] FUNC_PUT_CHAR    = 3'd1;
    localparam logic [2:0] FUNC_PIXEL       = 3'd2;
    localparam logic [2:0] FUNC_DECIMAL     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR_MATRIX = 3'd4;
    localparam logic [2:0] FUNC_CLEAR_ALL   = 3'd5;
    localparam logic [2:0] FUNC_READ_FRAME  = 3'd6;

    // frame store geometry
    localparam int          FRAME_BYTES = 64;
    localparam int          FRAME_AW    = 6;
    localparam logic [5:0]  FRAME_LAST  = 6'(FRAME_BYTES - 1);
    localparam logic [2:0]  ROW_LAST    = 3'd7;

    // decimal point locations
    localparam logic [2:0] DP_A_ROW = 3'd7;
    localparam logic [2:0] DP_A_BIT = 3'd6;
    localparam logic [2:0] DP_B_ROW = 3'd6;
    localparam logic [2:0] DP_B_BIT = 3'd7;

    // character code to glyph mapping
    localparam logic [7:0] CHAR_UPPER_FIRST = 8'h20;
    localparam logic [7:0] CHAR_UPPER_LAST  = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_FIRST = 8'h61;
    localparam logic [7:0] CHAR_LOWER_LAST  = 8'h7A;
    localparam logic [7:0] CHAR_LOWER_BASE  = 8'h26;

    typedef struct packed {
        logic [2:0] func;
        logic [6:0] glyph_index;
        logic [2:0] glyph_row;
        logic [7:0] glyph_bits;
        logic [2:0] position;
        logic [7:0] char_code;
        logic [1:0] chip;
        logic       matrix_sel;
        logic [2:0] px_x;
        logic [2:0] px_y;
        logic       turn_on;
    } t_in_word;

    typedef struct packed {
        logic [1:0] out_chip;
        logic       out_matrix;
        logic [2:0] out_row;
        logic [7:0] out_bits;
        logic       last;
    } t_out_word;

    // row unit operations
    typedef enum logic [1:0] {
        ROW_COPY      = 2'd0,
        ROW_TRANSPOSE = 2'd1,
        ROW_MODIFY    = 2'd2
    } t_row_op;

    typedef struct packed {
        t_row_op    op;
        logic [2:0] idx;
        logic [2:0] bit_sel;
        logic       turn_on;
    } t_row_ctl;

endpackage

// File: rtl/led_matrix_char_framebuffer.sv
// top level of the led matrix character frame buffer: sequencer, stores
// depends on lmcf_pkg, lmcf_ram, lmcf_row_unit, led_matrix_char_framebuffer_assert.svh
//
//   channel  | direction | handshake                  | word
//   ---------+-----------+----------------------------+-----------
//   in       | input     | i_in_valid / o_in_ready    | t_in_word
//   out      | output    | o_out_valid / i_out_ready  | t_out_word
//
// glyph load, clear matrix and clear all finish in the idle state; pixel and decimal
// point go through a frame ram read, the registered data and a write back
// put char does eight glyph reads, a wait for the last read data, eight row writes
// read frame reads, captures and holds the 64 words in turn, each until the output takes it
// the frame store is cleared at once by reset through per-entry valid bits
// ready is high only while the sequencer idles
`timescale 1ns / 1ps
`include "led_matrix_char_framebuffer_assert.svh"

module led_matrix_char_framebuffer #(
    parameter int GLYPH_COUNT = 85
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lmcf_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lmcf_pkg::t_out_word o_out_data
);

    import lmcf_pkg::*;

    localparam int GLYPH_DEPTH = GLYPH_COUNT * 8;
    localparam int GAW         = $clog2(GLYPH_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b0_0000_0001,
        S_GLYPH_RD   = 9'b0_0000_0010,
        S_GLYPH_WAIT = 9'b0_0000_0100,
        S_FRAME_WR   = 9'b0_0000_1000,
        S_PIX_RD     = 9'b0_0001_0000,
        S_PIX_WR     = 9'b0_0010_0000,
        S_OUT_RD     = 9'b0_0100_0000,
        S_OUT_CAP    = 9'b0_1000_0000,
        S_OUT_HOLD   = 9'b1_0000_0000
    } t_state;

    // control registers
    t_state          r_state,     n_state;
    logic [63:0]     r_fvalid,    n_fvalid;
    logic            r_rd_pend,   n_rd_pend;
    logic            r_out_valid, n_out_valid;

    // payload registers
    logic [5:0]      r_k,         n_k;
    logic [6:0]      r_glyph,     n_glyph;
    logic [2:0]      r_phys,      n_phys;
    logic [5:0]      r_faddr,     n_faddr;
    t_row_ctl        r_ctl,       n_ctl;
    logic [7:0][7:0] r_gbuf,      n_gbuf;
    logic [2:0]      r_rd_idx,    n_rd_idx;
    logic            r_fv_q;
    t_out_word       r_out,       n_out;

    // ram ports and row unit
    logic                g_we;
    logic [GAW-1:0]      g_waddr;
    logic [GAW-1:0]      g_raddr;
    logic [7:0]          g_rdata;
    logic                f_we;
    logic [FRAME_AW-1:0] f_waddr;
    logic [FRAME_AW-1:0] f_raddr;
    logic [7:0]          f_rdata;
    logic [7:0]          w_old;
    logic [7:0]          w_row;
    t_row_ctl            w_ctl;
    logic                w_in_acc;
    logic [2:0]          w_disp;
    logic [6:0]          w_gmap;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_disp      = {i_in_data.chip, i_in_data.matrix_sel};

    // character code to glyph number
    always_comb begin
        if (i_in_data.char_code >= CHAR_UPPER_FIRST && i_in_data.char_code <= CHAR_UPPER_LAST) begin
            w_gmap = 7'(i_in_data.char_code - CHAR_UPPER_FIRST);
        end else if (i_in_data.char_code >= CHAR_LOWER_FIRST &&
                     i_in_data.char_code <= CHAR_LOWER_LAST) begin
            w_gmap = 7'(i_in_data.char_code - CHAR_LOWER_BASE);
        end else begin
            w_gmap = 7'd0;
        end
    end

    // glyph store
    lmcf_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (i_in_data.glyph_bits),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    // frame store
    lmcf_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (w_row),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // shared row unit, step index from the counter
    always_comb begin
        w_ctl     = r_ctl;
        w_ctl.idx = r_k[2:0];
    end

    assign w_old = r_fv_q ? f_rdata : 8'd0;

    lmcf_row_unit u_row_unit (
        .i_ctl  (w_ctl),
        .i_rows (r_gbuf),
        .i_old  (w_old),
        .o_byte (w_row)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fvalid    = r_fvalid;
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid;
        n_k         = r_k;
        n_glyph     = r_glyph;
        n_phys      = r_phys;
        n_faddr     = r_faddr;
        n_ctl       = r_ctl;
        n_gbuf      = r_gbuf;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        g_we        = 1'b0;
        g_waddr     = GAW'({i_in_data.glyph_index, i_in_data.glyph_row});
        g_raddr     = GAW'({r_glyph, r_k[2:0]});
        f_we        = 1'b0;
        f_waddr     = r_faddr;
        f_raddr     = r_faddr;

        // capture a glyph row in the cycle after its read
        if (r_rd_pend) begin
            n_gbuf[r_rd_idx] = g_rdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_data.func)
                        FUNC_LOAD_GLYPH: begin
                            g_we = ({1'b0, i_in_data.glyph_index} < 8'(GLYPH_COUNT));
                        end
                        FUNC_PUT_CHAR: begin
                            n_glyph = w_gmap;
                            n_phys  = 3'(i_in_data.position + 3'd6);
                            n_ctl.op = n_phys[0] ? ROW_TRANSPOSE : ROW_COPY;
                            n_k     = 6'd0;
                            n_state = S_GLYPH_RD;
                        end
                        FUNC_PIXEL: begin
                            n_faddr = i_in_data.matrix_sel ? {w_disp, i_in_data.px_x}
                                                           : {w_disp, i_in_data.px_y};
                            n_ctl.bit_sel = i_in_data.matrix_sel ? i_in_data.px_y
                                                                 : i_in_data.px_x;
                            n_ctl.op      = ROW_MODIFY;
                            n_ctl.turn_on = i_in_data.turn_on;
                            n_state       = S_PIX_RD;
                        end
                        FUNC_DECIMAL: begin
                            n_faddr = i_in_data.matrix_sel ? {w_disp, DP_B_ROW}
                                                           : {w_disp, DP_A_ROW};
                            n_ctl.bit_sel = i_in_data.matrix_sel ? DP_B_BIT : DP_A_BIT;
                            n_ctl.op      = ROW_MODIFY;
                            n_ctl.turn_on = i_in_data.turn_on;
                            n_state       = S_PIX_RD;
                        end
                        FUNC_CLEAR_MATRIX: begin
                            n_fvalid[{w_disp, 3'd0} +: 8] = 8'd0;
                        end
                        FUNC_CLEAR_ALL: begin
                            n_fvalid = '0;
                        end
                        FUNC_READ_FRAME: begin
                            n_k     = 6'd0;
                            n_state = S_OUT_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_GLYPH_RD: begin
                n_rd_pend = 1'b1;
                n_rd_idx  = r_k[2:0];
                if (r_k[2:0] == ROW_LAST) begin
                    n_k     = 6'd0;
                    n_state = S_GLYPH_WAIT;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end
            S_GLYPH_WAIT: begin
                n_state = S_FRAME_WR;
            end
            S_FRAME_WR: begin
                f_we              = 1'b1;
                f_waddr           = {r_phys, r_k[2:0]};
                n_fvalid[f_waddr] = 1'b1;
                if (r_k[2:0] == ROW_LAST) begin
                    n_state = S_IDLE;
                end
                n_k = r_k + 6'd1;
            end
            S_PIX_RD: begin
                n_state = S_PIX_WR;
            end
            S_PIX_WR: begin
                f_we              = 1'b1;
                n_fvalid[r_faddr] = 1'b1;
                n_state           = S_IDLE;
            end
            S_OUT_RD: begin
                // matrix B (odd display) goes out first for each chip
                f_raddr = {r_k[5:4], ~r_k[3], r_k[2:0]};
                n_state = S_OUT_CAP;
            end
            S_OUT_CAP: begin
                n_out.out_chip   = r_k[5:4];
                n_out.out_matrix = r_k[3];
                n_out.out_row    = r_k[2:0];
                n_out.out_bits   = w_old;
                n_out.last       = (r_k == FRAME_LAST);
                n_out_valid      = 1'b1;
                n_state          = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_k == FRAME_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fvalid    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fvalid    <= n_fvalid;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_glyph  <= n_glyph;
        r_phys   <= n_phys;
        r_faddr  <= n_faddr;
        r_ctl    <= n_ctl;
        r_gbuf   <= n_gbuf;
        r_rd_idx <= n_rd_idx;
        r_out    <= n_out;
        r_fv_q   <= r_fvalid[f_raddr];
    end

    // checks
    logic w_last_acc;
    logic w_wr_state;

    assign w_last_acc = o_out_valid & i_out_ready & o_out_data.last;
    assign w_wr_state = (r_state == S_FRAME_WR) | (r_state == S_PIX_WR);

    `LMCF_ASSERT_NOW(a_out_only_in_hold, i_clk, i_rst_n, o_out_valid, r_state == S_OUT_HOLD)
    `LMCF_ASSERT_NOW(a_ready_no_pending_out, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `LMCF_ASSERT_NEXT(a_last_ends_readout, i_clk, i_rst_n, w_last_acc, r_state == S_IDLE)
    `LMCF_ASSERT_NOW(a_frame_write_state, i_clk, i_rst_n, f_we, w_wr_state)

endmodule

// File: rtl/lmcf_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lmcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lmcf_row_unit.sv
// shared row unit: copies, transposes or bit-modifies one frame row byte
// depends on lmcf_pkg
`timescale 1ns / 1ps

module lmcf_row_unit (
    input  lmcf_pkg::t_row_ctl   i_ctl,
    input  logic [7:0][7:0]      i_rows,
    input  logic [7:0]           i_old,
    output logic [7:0]           o_byte
);

    import lmcf_pkg::*;

    // one output byte per step
    always_comb begin
        o_byte = i_old;
        case (i_ctl.op)
            ROW_COPY: begin
                o_byte = i_rows[i_ctl.idx];
            end
            ROW_TRANSPOSE: begin
                for (int r = 0; r < 8; r++) begin
                    o_byte[r] = i_rows[r][i_ctl.idx];
                end
            end
            ROW_MODIFY: begin
                o_byte = i_old;
                o_byte[i_ctl.bit_sel] = i_ctl.turn_on;
            end
            default: begin
                o_byte = i_old;
            end
        endcase
    end

endmodule

// File: tb/lmcf_frame_checker.sv
// checker for the led matrix character frame buffer: predicts readout words
// from accepted command words and compares them with the output channel
// depends on lmcf_pkg
`timescale 1ns / 1ps

module lmcf_frame_checker #(
    parameter int GLYPH_COUNT = 85
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lmcf_pkg::t_in_word  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lmcf_pkg::t_out_word i_out_data,
    output int                  o_errors,
    output int                  o_pending
);

    import lmcf_pkg::*;

    // predicted frame and glyph contents
    logic [7:0] frame_rows [FRAME_BYTES];
    logic [7:0] glyph_rows [GLYPH_COUNT * 8];
    t_out_word  readout_q [$];
    int         mismatch_count = 0;

    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // character code to glyph number
    function automatic int glyph_of(logic [7:0] code);
        if (code >= CHAR_UPPER_FIRST && code <= CHAR_UPPER_LAST) begin
            return int'(code - CHAR_UPPER_FIRST);
        end
        if (code >= CHAR_LOWER_FIRST && code <= CHAR_LOWER_LAST) begin
            return int'(code - CHAR_LOWER_BASE);
        end
        return 0;
    endfunction

    // update the frame model and queue any readout words
    task automatic apply_word(input t_in_word w);
        logic [2:0] disp;
        logic [2:0] phys;
        logic [7:0] v;
        t_out_word  e;
        int         g;
        int         k;
        disp = {w.chip, w.matrix_sel};
        case (w.func)
            FUNC_LOAD_GLYPH: begin
                if (int'(w.glyph_index) < GLYPH_COUNT) begin
                    glyph_rows[int'(w.glyph_index) * 8 + int'(w.glyph_row)] = w.glyph_bits;
                end
            end
            FUNC_PUT_CHAR: begin
                phys = w.position + 3'd6;
                g = glyph_of(w.char_code);
                for (int r = 0; r < 8; r++) begin
                    if (!phys[0]) begin
                        v = glyph_rows[g * 8 + r];
                    end else begin
                        // odd displays are mounted turned, so take the transpose
                        for (int c = 0; c < 8; c++) begin
                            v[c] = glyph_rows[g * 8 + c][r];
                        end
                    end
                    frame_rows[{phys, 3'(r)}] = v;
                end
            end
            FUNC_PIXEL: begin
                if (!w.matrix_sel) begin
                    frame_rows[{disp, w.px_y}][w.px_x] = w.turn_on;
                end else begin
                    frame_rows[{disp, w.px_x}][w.px_y] = w.turn_on;
                end
            end
            FUNC_DECIMAL: begin
                if (!w.matrix_sel) begin
                    frame_rows[{disp, DP_A_ROW}][DP_A_BIT] = w.turn_on;
                end else begin
                    frame_rows[{disp, DP_B_ROW}][DP_B_BIT] = w.turn_on;
                end
            end
            FUNC_CLEAR_MATRIX: begin
                for (int r = 0; r < 8; r++) begin
                    frame_rows[{disp, 3'(r)}] = '0;
                end
            end
            FUNC_CLEAR_ALL: begin
                foreach (frame_rows[a]) frame_rows[a] = '0;
            end
            FUNC_READ_FRAME: begin
                // per chip: matrix b first, then matrix a
                k = 0;
                for (int c = 0; c < 4; c++) begin
                    for (int h = 0; h < 2; h++) begin
                        for (int r = 0; r < 8; r++) begin
                            e.out_chip   = 2'(c);
                            e.out_matrix = 1'(h);
                            e.out_row    = 3'(r);
                            e.out_bits   = frame_rows[{2'(c), ~1'(h), 3'(r)}];
                            e.last       = (k == FRAME_BYTES - 1);
                            readout_q.push_back(e);
                            k++;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // compare one output word with the oldest prediction
    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (readout_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", got));
        end else begin
            want = readout_q.pop_front();
            if (got.out_chip !== want.out_chip)
                report_mismatch($sformatf("out_chip got %0d expected %0d",
                                          got.out_chip, want.out_chip));
            if (got.out_matrix !== want.out_matrix)
                report_mismatch($sformatf("out_matrix got %0d expected %0d",
                                          got.out_matrix, want.out_matrix));
            if (got.out_row !== want.out_row)
                report_mismatch($sformatf("out_row got %0d expected %0d",
                                          got.out_row, want.out_row));
            if (got.out_bits !== want.out_bits)
                report_mismatch($sformatf("out_bits got %h expected %h (chip %0d mat %0d row %0d)",
                                          got.out_bits, want.out_bits, want.out_chip,
                                          want.out_matrix, want.out_row));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0d expected %0d", got.last, want.last));
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_rows[a]) frame_rows[a] = '0;
            readout_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_word(i_out_data);
            if (i_in_valid && i_in_ready) apply_word(i_in_data);
        end
        o_pending = readout_q.size();
    end

endmodule

// File: tb/tb_led_matrix_char_framebuffer.sv
// testbench top for the led matrix character frame buffer: clock, reset,
// command stimulus, output back pressure and the final verdict
// depends on lmcf_pkg, led_matrix_char_framebuffer, lmcf_frame_checker
`timescale 1ns / 1ps

module tb_led_matrix_char_framebuffer;
    import lmcf_pkg::*;

    localparam int         GLYPH_COUNT     = 85;
    localparam int         ITEM_TARGET     = 450;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam logic [2:0] FUNC_UNUSED     = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_data;
    int        error_count;
    int        pending_words;

    bit         hold_off_req;
    bit         tx_burst;
    bit   [7:0] glyph_rows_seen [GLYPH_COUNT];
    int         ready_glyphs [$];
    int         items_sent;

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    led_matrix_char_framebuffer #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    lmcf_frame_checker #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) frame_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .o_errors   (error_count),
        .o_pending  (pending_words)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // word with every field random; callers set the fields that matter
    function automatic t_in_word noise_word();
        logic [63:0] raw;
        t_in_word    w;
        raw = {$urandom, $urandom};
        w = raw[$bits(t_in_word)-1:0];
        return w;
    endfunction

    function automatic t_in_word op_word(logic [2:0] func);
        t_in_word w;
        w = noise_word();
        w.func = func;
        return w;
    endfunction

    function automatic t_in_word glyph_word(int g, int r, logic [7:0] bits);
        t_in_word w;
        w = op_word(FUNC_LOAD_GLYPH);
        w.glyph_index = 7'(g);
        w.glyph_row   = 3'(r);
        w.glyph_bits  = bits;
        return w;
    endfunction

    function automatic t_in_word char_word(int pos, logic [7:0] code);
        t_in_word w;
        w = op_word(FUNC_PUT_CHAR);
        w.position  = 3'(pos);
        w.char_code = code;
        return w;
    endfunction

    // pixel, decimal point and clear matrix share the target fields
    function automatic t_in_word mark_word(logic [2:0] func, int chip, bit msel,
                                           int x, int y, bit on);
        t_in_word w;
        w = op_word(func);
        w.chip       = 2'(chip);
        w.matrix_sel = msel;
        w.px_x       = 3'(x);
        w.px_y       = 3'(y);
        w.turn_on    = on;
        return w;
    endfunction

    // some character code that selects glyph g
    function automatic logic [7:0] code_for_glyph(int g);
        if (g == 0) begin
            case ($urandom_range(0, 3))
                0: return CHAR_UPPER_FIRST;
                1: return 8'($urandom_range(0, CHAR_UPPER_FIRST - 1));
                2: return 8'($urandom_range(CHAR_UPPER_LAST + 1, CHAR_LOWER_FIRST - 1));
                default: return 8'($urandom_range(CHAR_LOWER_LAST + 1, 255));
            endcase
        end
        if (g <= CHAR_UPPER_LAST - CHAR_UPPER_FIRST) return 8'(g + CHAR_UPPER_FIRST);
        return 8'(g + CHAR_LOWER_BASE);
    endfunction

    // offer one word after a random gap (none in burst mode); returns just after it is taken
    task automatic send_word(input t_in_word w);
        int gap;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        // a glyph may be shown only once all its rows are written
        if (w.func == FUNC_LOAD_GLYPH && int'(w.glyph_index) < GLYPH_COUNT) begin
            if (glyph_rows_seen[w.glyph_index] != 8'hFF) begin
                glyph_rows_seen[w.glyph_index][w.glyph_row] = 1'b1;
                if (glyph_rows_seen[w.glyph_index] == 8'hFF)
                    ready_glyphs.push_back(int'(w.glyph_index));
            end
            items_sent++;
        end else if (w.func != FUNC_UNUSED && w.func != FUNC_LOAD_GLYPH) begin
            items_sent++;
        end
    endtask

    // stop offering and wait for every predicted word
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
    endtask

    task automatic load_glyph(input int g);
        for (int r = 0; r < 8; r++) send_word(glyph_word(g, r, 8'($urandom)));
    endtask

    task automatic put_random_char();
        int g;
        g = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
        send_word(char_word($urandom_range(0, 7), code_for_glyph(g)));
    endtask

    task automatic random_mark();
        logic [2:0] func;
        case ($urandom_range(0, 2))
            0: func = FUNC_PIXEL;
            1: func = FUNC_DECIMAL;
            default: func = FUNC_CLEAR_MATRIX;
        endcase
        send_word(mark_word(func, $urandom_range(0, 3), 1'($urandom),
                            $urandom_range(0, 7), $urandom_range(0, 7), 1'($urandom)));
    endtask

    // output side: random stalls, free-running stretches, one long hold-off
    initial begin
        int stall_left;
        int free_left;
        out_ready  = 1'b0;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 299) == 0) begin
                    free_left = 200;
                end else if ($urandom_range(0, 2) == 0) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    // run time limit
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // command stimulus
    initial begin
        logic [7:0] corner_rows [8];
        int pick;
        int round;
        int g;
        corner_rows  = '{8'h00, 8'hFF, 8'h81, 8'h7E,
                         8'h01, 8'h80, 8'hA5, 8'h5A};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        hold_off_req = 1'b0;
        tx_burst     = 1'b0;
        items_sent   = 0;
        foreach (glyph_rows_seen[i]) glyph_rows_seen[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: glyph extremes, ignored load, both orientations, every op
        for (int r = 0; r < 8; r++) send_word(glyph_word(0, r, corner_rows[r]));
        load_glyph(GLYPH_COUNT - 1);
        send_word(glyph_word(127, 7, 8'hFF));
        send_word(char_word(0, CHAR_LOWER_LAST));
        send_word(char_word(1, 8'hFF));
        send_word(mark_word(FUNC_PIXEL, 3, 1'b0, 7, 0, 1'b1));
        send_word(mark_word(FUNC_PIXEL, 0, 1'b1, 0, 7, 1'b1));
        send_word(mark_word(FUNC_DECIMAL, 1, 1'b0, 0, 0, 1'b1));
        send_word(mark_word(FUNC_DECIMAL, 2, 1'b1, 0, 0, 1'b1));
        send_word(op_word(FUNC_READ_FRAME));
        send_word(mark_word(FUNC_CLEAR_MATRIX, 3, 1'b0, 0, 0, 1'b0));
        send_word(op_word(FUNC_UNUSED));
        send_word(op_word(FUNC_READ_FRAME));
        send_word(op_word(FUNC_CLEAR_ALL));
        send_word(op_word(FUNC_READ_FRAME));
        wait_drained();

        // random commands
        round = 0;
        while (items_sent < ITEM_TARGET) begin
            if (round % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            if (round % 90 == 45) wait_drained();
            if (round == 60) begin
                // stall the output long enough that the input backs up
                wait_drained();
                @(posedge clk);
                hold_off_req = 1'b1;
                send_word(op_word(FUNC_READ_FRAME));
                repeat (4) random_mark();
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // whole glyph, often one at the edges of the code map
                case ($urandom_range(0, 6))
                    0: g = 0;
                    1: g = CHAR_UPPER_LAST - CHAR_UPPER_FIRST;
                    2: g = CHAR_LOWER_FIRST - CHAR_LOWER_BASE;
                    3: g = GLYPH_COUNT - 1;
                    default: g = $urandom_range(0, GLYPH_COUNT - 1);
                endcase
                load_glyph(g);
            end else if (pick < 16) begin
                send_word(glyph_word($urandom_range(0, GLYPH_COUNT - 1),
                                     $urandom_range(0, 7), 8'($urandom)));
            end else if (pick < 20) begin
                send_word(glyph_word($urandom_range(GLYPH_COUNT, 127),
                                     $urandom_range(0, 7), 8'($urandom)));
            end else if (pick < 45) begin
                put_random_char();
            end else if (pick < 78) begin
                random_mark();
            end else if (pick < 80) begin
                send_word(op_word(FUNC_CLEAR_ALL));
            end else if (pick < 92) begin
                send_word(op_word(FUNC_READ_FRAME));
            end else begin
                send_word(op_word(FUNC_UNUSED));
            end
            round++;
        end

        // drain and let a last put char settle
        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
